### sv/bpac_pkg.sv
package bpac_pkg;

    localparam int RawWidth  = 24;
    localparam int CoefWidth = 16;
    localparam int TempWidth = 19;
    localparam int PresWidth = 18;
    localparam int AltWidth  = 21;
    localparam int IdxWidth  = 8;

    localparam logic [IdxWidth-1:0] REG_PRESSURE_SENSITIVITY   = 8'd0;
    localparam logic [IdxWidth-1:0] REG_PRESSURE_OFFSET        = 8'd1;
    localparam logic [IdxWidth-1:0] REG_SENSITIVITY_TEMP_COEFF = 8'd2;
    localparam logic [IdxWidth-1:0] REG_OFFSET_TEMP_COEFF      = 8'd3;
    localparam logic [IdxWidth-1:0] REG_REFERENCE_TEMPERATURE  = 8'd4;
    localparam logic [IdxWidth-1:0] REG_TEMPERATURE_SLOPE      = 8'd5;

    localparam logic signed [20:0] TEMP_BASE    = 21'sd2000;
    localparam logic signed [19:0] LUT_START_PA = 20'sd104908;
    localparam logic [8:0]         LUT_LAST_IDX = 9'd76;
    localparam logic [PresWidth-1:0] PRESSURE_MAX = 18'd262143;

    typedef struct packed {
        logic [CoefWidth-1:0] pressure_sensitivity;
        logic [CoefWidth-1:0] pressure_offset;
        logic [CoefWidth-1:0] sensitivity_temp_coeff;
        logic [CoefWidth-1:0] offset_temp_coeff;
        logic [CoefWidth-1:0] reference_temperature;
        logic [CoefWidth-1:0] temperature_slope;
    } bpac_cfg_t;

    typedef struct packed {
        logic signed [TempWidth-1:0] temperature_centideg;
        logic [PresWidth-1:0]        pressure_pa;
    } bpac_comp_t;

    function automatic logic signed [AltWidth-1:0] alt_lut(input logic [6:0] idx);
        logic signed [AltWidth-1:0] z;
        case (idx)
            7'd0:  z = -21'sd29408;
            7'd1:  z = -21'sd21087;
            7'd2:  z = -21'sd12700;
            7'd3:  z = -21'sd4244;
            7'd4:  z = 21'sd4279;
            7'd5:  z = 21'sd12874;
            7'd6:  z = 21'sd21541;
            7'd7:  z = 21'sd30281;
            7'd8:  z = 21'sd39095;
            7'd9:  z = 21'sd47986;
            7'd10: z = 21'sd56953;
            7'd11: z = 21'sd66000;
            7'd12: z = 21'sd75126;
            7'd13: z = 21'sd84335;
            7'd14: z = 21'sd93628;
            7'd15: z = 21'sd103006;
            7'd16: z = 21'sd112472;
            7'd17: z = 21'sd122026;
            7'd18: z = 21'sd131672;
            7'd19: z = 21'sd141410;
            7'd20: z = 21'sd151244;
            7'd21: z = 21'sd161174;
            7'd22: z = 21'sd171204;
            7'd23: z = 21'sd181335;
            7'd24: z = 21'sd191570;
            7'd25: z = 21'sd201911;
            7'd26: z = 21'sd212361;
            7'd27: z = 21'sd222922;
            7'd28: z = 21'sd233597;
            7'd29: z = 21'sd244388;
            7'd30: z = 21'sd255300;
            7'd31: z = 21'sd266334;
            7'd32: z = 21'sd277494;
            7'd33: z = 21'sd288782;
            7'd34: z = 21'sd300204;
            7'd35: z = 21'sd311761;
            7'd36: z = 21'sd323457;
            7'd37: z = 21'sd335297;
            7'd38: z = 21'sd347285;
            7'd39: z = 21'sd359424;
            7'd40: z = 21'sd371719;
            7'd41: z = 21'sd384174;
            7'd42: z = 21'sd396795;
            7'd43: z = 21'sd409586;
            7'd44: z = 21'sd422552;
            7'd45: z = 21'sd435700;
            7'd46: z = 21'sd449033;
            7'd47: z = 21'sd462560;
            7'd48: z = 21'sd476285;
            7'd49: z = 21'sd490216;
            7'd50: z = 21'sd504360;
            7'd51: z = 21'sd518724;
            7'd52: z = 21'sd533316;
            7'd53: z = 21'sd548144;
            7'd54: z = 21'sd563216;
            7'd55: z = 21'sd578543;
            7'd56: z = 21'sd594134;
            7'd57: z = 21'sd609999;
            7'd58: z = 21'sd626149;
            7'd59: z = 21'sd642595;
            7'd60: z = 21'sd659352;
            7'd61: z = 21'sd676431;
            7'd62: z = 21'sd693847;
            7'd63: z = 21'sd711615;
            7'd64: z = 21'sd729752;
            7'd65: z = 21'sd748275;
            7'd66: z = 21'sd767202;
            7'd67: z = 21'sd786555;
            7'd68: z = 21'sd806356;
            7'd69: z = 21'sd826627;
            7'd70: z = 21'sd847395;
            7'd71: z = 21'sd868688;
            7'd72: z = 21'sd890537;
            7'd73: z = 21'sd912974;
            7'd74: z = 21'sd936037;
            7'd75: z = 21'sd959766;
            7'd76: z = 21'sd984206;
            default: z = '0;
        endcase
        return z;
    endfunction

endpackage

### sv/bpac_comp.sv
module bpac_comp
    import bpac_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bpac_cfg_t            cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [RawWidth-1:0]  in_raw_pressure,
    input  logic [RawWidth-1:0]  in_raw_temperature,
    output logic                 out_valid,
    input  logic                 out_ready,
    output bpac_comp_t           out_data
);

    localparam int Stages = 6;

    logic [Stages-1:0] vld_reg;
    logic [Stages-1:0] en;

    // stage 1
    logic signed [25:0] dt_next, dt_reg;
    logic [RawWidth-1:0] d1_s1_reg;
    // stage 2
    logic signed [42:0] prod_t_next, prod_o_next, prod_s_next;
    logic signed [42:0] prod_t_reg, prod_o_reg, prod_s_reg;
    logic [RawWidth-1:0] d1_s2_reg;
    // stage 3
    logic signed [20:0] temp_wide;
    logic signed [TempWidth-1:0] temp_next, temp_s3_reg, temp_s4_reg, temp_s5_reg;
    logic signed [TempWidth-1:0] temp_s6_reg;
    logic signed [37:0] off_next, sens_next, off_s3_reg, sens_reg, off_s4_reg, off_s5_reg;
    logic [RawWidth-1:0] d1_s3_reg;
    // stage 4
    logic signed [46:0] pp_hi_next, pp_hi_reg;
    logic [39:0] pp_lo_next, pp_lo_reg;
    // stage 5
    logic signed [63:0] full;
    logic signed [41:0] x_next, x_reg;
    // stage 6
    logic signed [42:0] y;
    logic signed [42:0] pq;
    logic [PresWidth-1:0] p_next, p_reg;

    always_comb begin
        en[Stages-1] = !vld_reg[Stages-1] || out_ready;
        for (int i = Stages - 2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign in_ready = en[0];
    assign out_valid = vld_reg[Stages-1];
    assign out_data.temperature_centideg = temp_s6_reg;
    assign out_data.pressure_pa = p_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < Stages; i++) begin
                if (en[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_comb begin
        dt_next = $signed({2'b00, in_raw_temperature})
                - $signed({2'b00, cfg.reference_temperature, 8'h00});

        prod_t_next = 43'(dt_reg) * 43'($signed({1'b0, cfg.temperature_slope}));
        prod_o_next = 43'(dt_reg) * 43'($signed({1'b0, cfg.offset_temp_coeff}));
        prod_s_next = 43'(dt_reg) * 43'($signed({1'b0, cfg.sensitivity_temp_coeff}));

        temp_wide = TEMP_BASE + 21'(prod_t_reg >>> 23);
        temp_next = temp_wide[TempWidth-1:0];
        off_next  = $signed({5'b0, cfg.pressure_offset, 17'b0}) + 38'(prod_o_reg >>> 6);
        sens_next = $signed({6'b0, cfg.pressure_sensitivity, 16'b0})
                  + 38'(prod_s_reg >>> 7);

        pp_hi_next = 47'($signed({1'b0, d1_s3_reg})) * 47'($signed(sens_reg[37:16]));
        pp_lo_next = 40'(d1_s3_reg) * 40'(sens_reg[15:0]);

        full   = (64'(pp_hi_reg) <<< 16) + $signed({24'b0, pp_lo_reg});
        x_next = 42'(full >>> 21);

        y  = 43'(x_reg) - 43'(off_s5_reg);
        pq = y >>> 15;
        if (pq < 0) begin
            p_next = '0;
        end else if (pq > $signed({25'b0, PRESSURE_MAX})) begin
            p_next = PRESSURE_MAX;
        end else begin
            p_next = pq[PresWidth-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            dt_reg    <= dt_next;
            d1_s1_reg <= in_raw_pressure;
        end
        if (en[1]) begin
            prod_t_reg <= prod_t_next;
            prod_o_reg <= prod_o_next;
            prod_s_reg <= prod_s_next;
            d1_s2_reg  <= d1_s1_reg;
        end
        if (en[2]) begin
            temp_s3_reg <= temp_next;
            off_s3_reg  <= off_next;
            sens_reg    <= sens_next;
            d1_s3_reg   <= d1_s2_reg;
        end
        if (en[3]) begin
            pp_hi_reg   <= pp_hi_next;
            pp_lo_reg   <= pp_lo_next;
            temp_s4_reg <= temp_s3_reg;
            off_s4_reg  <= off_s3_reg;
        end
        if (en[4]) begin
            x_reg       <= x_next;
            temp_s5_reg <= temp_s4_reg;
            off_s5_reg  <= off_s4_reg;
        end
        if (en[5]) begin
            p_reg       <= p_next;
            temp_s6_reg <= temp_s5_reg;
        end
    end

endmodule

### sv/bpac_alt.sv
module bpac_alt
    import bpac_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  bpac_comp_t                 in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output bpac_comp_t                 out_data,
    output logic signed [AltWidth-1:0] out_altitude
);

    localparam int Stages = 3;

    logic [Stages-1:0] vld_reg;
    logic [Stages-1:0] en;

    logic signed [19:0] diff;
    logic [8:0] q;
    logic [6:0] idx;
    logic signed [AltWidth-1:0] z1_next, z2;
    logic signed [AltWidth-1:0] dz_wide;
    logic signed [15:0] dz_next;
    logic [9:0] frac_next;

    logic signed [AltWidth-1:0] z1_s1_reg, z1_s2_reg;
    logic signed [15:0] dz_reg;
    logic [9:0] frac_reg;
    logic signed [26:0] prod_next, prod_reg;
    logic signed [AltWidth-1:0] alt_next, alt_reg;
    bpac_comp_t data_s1_reg, data_s2_reg, data_s3_reg;

    always_comb begin
        en[Stages-1] = !vld_reg[Stages-1] || out_ready;
        for (int i = Stages - 2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign in_ready = en[0];
    assign out_valid = vld_reg[Stages-1];
    assign out_data = data_s3_reg;
    assign out_altitude = alt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < Stages; i++) begin
                if (en[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_comb begin
        diff      = LUT_START_PA - $signed({2'b00, in_data.pressure_pa});
        q         = diff[18:10];
        idx       = q[6:0];
        frac_next = diff[9:0];
        z2        = alt_lut(7'(idx + 7'd1));
        if (diff[19]) begin
            z1_next = alt_lut(7'd0);
            dz_next = '0;
        end else if (q >= LUT_LAST_IDX) begin
            z1_next = alt_lut(LUT_LAST_IDX[6:0]);
            dz_next = '0;
        end else begin
            z1_next = alt_lut(idx);
            dz_next = dz_wide[15:0];
        end

        prod_next = 27'($signed({1'b0, frac_reg})) * 27'(dz_reg);
        alt_next  = z1_s2_reg + 21'(prod_reg >>> 10);
    end

    assign dz_wide = z2 - alt_lut(idx);

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            z1_s1_reg   <= z1_next;
            dz_reg      <= dz_next;
            frac_reg    <= frac_next;
            data_s1_reg <= in_data;
        end
        if (en[1]) begin
            prod_reg    <= prod_next;
            z1_s2_reg   <= z1_s1_reg;
            data_s2_reg <= data_s1_reg;
        end
        if (en[2]) begin
            alt_reg     <= alt_next;
            data_s3_reg <= data_s2_reg;
        end
    end

endmodule

### sv/baro_pressure_altitude_convert.sv
// Pipeline: 9 register stages (6 compensation, 3 altitude).
// Throughput: one item per cycle while m_ready is high; each stage advances
// when empty or its successor advances, so bubbles close up under output stall.
// Reset: aresetn synchronous, active low; clears all stage valid bits and sets
// the six calibration registers to zero.
module baro_pressure_altitude_convert
    import bpac_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [IdxWidth-1:0]         cfg_index,
    input  logic [CoefWidth-1:0]        cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [RawWidth-1:0]         s_raw_pressure,
    input  logic [RawWidth-1:0]         s_raw_temperature,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [TempWidth-1:0] m_temperature_centideg,
    output logic [PresWidth-1:0]        m_pressure_pa,
    output logic signed [AltWidth-1:0]  m_altitude_cm
);

    bpac_cfg_t  cfg_reg;
    bpac_comp_t comp_data, alt_data;
    logic       comp_valid, comp_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PRESSURE_SENSITIVITY:   cfg_reg.pressure_sensitivity   <= cfg_data;
                REG_PRESSURE_OFFSET:        cfg_reg.pressure_offset        <= cfg_data;
                REG_SENSITIVITY_TEMP_COEFF: cfg_reg.sensitivity_temp_coeff <= cfg_data;
                REG_OFFSET_TEMP_COEFF:      cfg_reg.offset_temp_coeff      <= cfg_data;
                REG_REFERENCE_TEMPERATURE:  cfg_reg.reference_temperature  <= cfg_data;
                REG_TEMPERATURE_SLOPE:      cfg_reg.temperature_slope      <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    bpac_comp u_comp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg                (cfg_reg),
        .in_valid           (s_valid),
        .in_ready           (s_ready),
        .in_raw_pressure    (s_raw_pressure),
        .in_raw_temperature (s_raw_temperature),
        .out_valid          (comp_valid),
        .out_ready          (comp_ready),
        .out_data           (comp_data)
    );

    bpac_alt u_alt (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (comp_valid),
        .in_ready     (comp_ready),
        .in_data      (comp_data),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .out_data     (alt_data),
        .out_altitude (m_altitude_cm)
    );

    assign m_temperature_centideg = alt_data.temperature_centideg;
    assign m_pressure_pa          = alt_data.pressure_pa;

endmodule
